/* rtl/dead_layer_energy_correction_assert.svh */
// Assertion macros shared by the RTL. Each one samples on the rising edge of clk and is
// disabled while rst is high.
`ifndef DEAD_LAYER_ENERGY_CORRECTION_ASSERT_SVH
`define DEAD_LAYER_ENERGY_CORRECTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DLEC_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DLEC_ASSERT_IMP(name, pre, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (cond)) else $error(msg);
`define DLEC_ASSERT_NEXT(name, pre, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (cond)) else $error(msg);
`else
`define DLEC_ASSERT(name, cond, msg)
`define DLEC_ASSERT_IMP(name, pre, cond, msg)
`define DLEC_ASSERT_NEXT(name, pre, cond, msg)
`endif
`endif

/* rtl/dlec_pkg.sv */
package dlec_pkg;

  localparam int FRAC_BITS  = 4;
  localparam int E_W        = 16;
  localparam int T_W        = 16;
  localparam int K_W        = 17;
  localparam int E_INT_FRAC = 8;
  localparam int T_FRAC     = 8;
  localparam int F0_SCALE   = 16;
  localparam int OUT_SHIFT  = F0_SCALE - FRAC_BITS;

  localparam int NUM_COEF  = 5;
  localparam int NUM_TERMS = 4;
  localparam int K_IDX_W   = $clog2(NUM_COEF);
  localparam int J_IDX_W   = $clog2(NUM_TERMS);
  localparam int SH_W      = 5;

  // Energy path: widened energy and the running Horner value.
  localparam int X_W    = E_W + E_INT_FRAC - FRAC_BITS;
  localparam int B_W    = (FRAC_BITS < 4) ? 42 + 4 * (4 - FRAC_BITS) : 42;
  localparam int B_LO_W = B_W / 2;
  localparam int B_HI_W = B_W - B_LO_W;

  // Thickness path: accumulator of the coefficient polynomials.
  localparam int A_W    = 56;
  localparam int A_LO_W = A_W / 2;
  localparam int A_HI_W = A_W - A_LO_W;

  // Three stages per cell plus rounding and clipping.
  localparam int PIPE_DEPTH = 3 * NUM_TERMS + 2;
  localparam int FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

  localparam logic [T_W-1:0]        THICK_RESET = T_W'(15258);
  localparam logic signed [K_W-1:0] KE_MAX      = K_W'(65535);
  localparam logic signed [K_W-1:0] KE_MIN      = K_W'(-65536);

  typedef struct packed {
    logic                  valid;
    logic [X_W-1:0]        x;
    logic signed [B_W-1:0] b;
  } hc_bus_t;

  typedef struct packed {
    logic busy;
    logic cfg_ready;
  } coef_status_t;

  typedef logic [NUM_COEF-1:0][B_W-1:0] coef_vec_t;
  typedef logic [NUM_COEF-1:0][NUM_TERMS-1:0][A_W-1:0] coef_tab_t;

  typedef struct packed {
    int mant;
    int dexp;
  } dec_t;

  function automatic int thick_scale(int k);
    case (k)
      0:       return 40;
      1:       return 44;
      2:       return 56;
      3:       return 68;
      default: return 76;
    endcase
  endfunction

  function automatic int energy_scale(int k);
    case (k)
      0:       return 16;
      1:       return 18;
      2:       return 34;
      3:       return 48;
      default: return 64;
    endcase
  endfunction

  function automatic int horner_shift(int k);
    return energy_scale(k + 1) + E_INT_FRAC - energy_scale(k);
  endfunction

  function automatic int rescale_shift(int k);
    return thick_scale(k) - energy_scale(k);
  endfunction

  // Decimal constants mant * 10^-dexp, row k is coefficient k, column j the power of t.
  function automatic dec_t dec_value(int k, int j);
    dec_t d;
    case (k * NUM_TERMS + j)
      0:       d = '{mant: -5174, dexp: 4};
      1:       d = '{mant: 4172,  dexp: 4};
      2:       d = '{mant: 3610,  dexp: 6};
      3:       d = '{mant: -1286, dexp: 9};
      4:       d = '{mant: 10000, dexp: 4};
      5:       d = '{mant: 8703,  dexp: 6};
      6:       d = '{mant: 1252,  dexp: 8};
      7:       d = '{mant: 6948,  dexp: 11};
      8:       d = '{mant: 2990,  dexp: 9};
      9:       d = '{mant: -7937, dexp: 9};
      10:      d = '{mant: -2219, dexp: 11};
      11:      d = '{mant: -2877, dexp: 13};
      12:      d = '{mant: -8258, dexp: 12};
      13:      d = '{mant: 4031,  dexp: 12};
      14:      d = '{mant: 9673,  dexp: 16};
      15:      d = '{mant: 3661,  dexp: 16};
      16:      d = '{mant: 3652,  dexp: 15};
      17:      d = '{mant: -8652, dexp: 16};
      18:      d = '{mant: 4059,  dexp: 18};
      default: d = '{mant: -1294, dexp: 19};
    endcase
    return d;
  endfunction

  // Rounded mant * 10^-dexp * 2^g by restoring long division of |mant| * 2^(g-dexp)
  // by 5^dexp, ties away from zero.
  function automatic logic signed [A_W-1:0] scale_const(int mant, int dexp, int g);
    logic [63:0]           d;
    logic [63:0]           q;
    logic [63:0]           r;
    logic [15:0]           n;
    logic signed [A_W-1:0] qs;
    int                    sh;
    int                    i;
    d = 64'd1;
    for (i = 0; i < dexp; i++) d = d * 64'd5;
    n  = (mant < 0) ? 16'(-mant) : 16'(mant);
    sh = g - dexp;
    q  = '0;
    r  = '0;
    for (i = 15 + sh; i >= 0; i--) begin
      r = {r[62:0], (i >= sh) ? n[i - sh] : 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    if ({r[62:0], 1'b0} >= d) q = q + 64'd1;
    qs = q[A_W-1:0];
    if (mant < 0) qs = -qs;
    return qs;
  endfunction

  function automatic coef_tab_t build_coef_tab();
    coef_tab_t tab;
    dec_t      dc;
    int        k;
    int        j;
    for (k = 0; k < NUM_COEF; k++) begin
      for (j = 0; j < NUM_TERMS; j++) begin
        dc        = dec_value(k, j);
        tab[k][j] = scale_const(dc.mant, dc.dexp, thick_scale(k));
      end
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef_tab();

endpackage

/* rtl/dead_layer_energy_correction.sv */
// A result is strobed on done once its start transfer has passed three stages in each
// of the four Horner cells, one rounding stage and one clipping stage.
// Throughput: one item per cycle; start is ignored while busy is high.
// Reset and every thickness write start the sequencer with busy high; per coefficient it
// loads the top term, then multiplies, rounds and adds per further term, and rescales.
// Results cannot be stalled by the receiver and appear for one cycle each.
`include "dead_layer_energy_correction_assert.svh"

module dead_layer_energy_correction (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dlec_pkg::E_W-1:0]       energy_deposit,
  output logic                           done,
  output logic signed [dlec_pkg::K_W-1:0] kinetic_energy,
  output logic                           saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlec_pkg::T_W-1:0]       dead_layer_thickness
);
  import dlec_pkg::*;

  coef_status_t          cstat;
  coef_vec_t             coef_vec;
  hc_bus_t               bus [NUM_TERMS+1];
  logic                  accept;
  logic [FLIGHT_W-1:0]   in_flight;
  logic                  r_valid;
  logic signed [B_W-1:0] r_val;
  logic signed [B_W-1:0] b0;
  logic signed [B_W-1:0] r_sum;
  logic signed [B_W-1:0] r_next;

  assign busy      = cstat.busy;
  assign cfg_ready = cstat.cfg_ready;
  assign accept    = start && !busy;

  dlec_coef_unit u_coef (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (dead_layer_thickness),
    .pipe_empty (in_flight == '0),
    .status     (cstat),
    .coef       (coef_vec)
  );

  assign bus[0].valid = accept;
  assign bus[0].x     = X_W'(energy_deposit) << (E_INT_FRAC - FRAC_BITS);
  assign bus[0].b     = coef_vec[NUM_COEF-1];

  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_cell
    dlec_horner_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .din   (bus[i]),
      .coef  (coef_vec[NUM_TERMS-1-i]),
      .shift (SH_W'(horner_shift(NUM_TERMS - 1 - i))),
      .dout  (bus[i+1])
    );
  end

  assign b0 = bus[NUM_TERMS].b;

  always_comb begin
    r_sum  = b0 + (B_W'(1) << (OUT_SHIFT - 1)) - B_W'(b0[B_W-1]);
    r_next = r_sum >>> OUT_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      done      <= 1'b0;
      in_flight <= '0;
    end else begin
      r_valid   <= bus[NUM_TERMS].valid;
      done      <= r_valid;
      in_flight <= in_flight + FLIGHT_W'(accept) - FLIGHT_W'(done);
    end
    r_val <= r_next;
    if (r_val > B_W'(KE_MAX)) begin
      kinetic_energy <= KE_MAX;
      saturated      <= 1'b1;
    end else if (r_val < B_W'(KE_MIN)) begin
      kinetic_energy <= KE_MIN;
      saturated      <= 1'b1;
    end else begin
      kinetic_energy <= r_val[K_W-1:0];
      saturated      <= 1'b0;
    end
  end

  // An item stays counted through its done cycle.
  `DLEC_ASSERT_IMP(a_sat_clip, done && saturated,
                   kinetic_energy == KE_MAX || kinetic_energy == KE_MIN,
                   "saturated result is not at a range end")
  `DLEC_ASSERT(a_flight_bound, in_flight <= FLIGHT_W'(PIPE_DEPTH + 1),
               "more items in flight than the pipeline holds")
  `DLEC_ASSERT_IMP(a_done_owned, done, in_flight != '0,
                   "result transfer without an item in flight")
  `DLEC_ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready, busy,
                    "thickness write did not start the coefficient sequencer")

endmodule

/* rtl/dlec_coef_unit.sv */
module dlec_coef_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [dlec_pkg::T_W-1:0] cfg_data,
  input  logic                    pipe_empty,
  output dlec_pkg::coef_status_t  status,
  output dlec_pkg::coef_vec_t     coef
);
  import dlec_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_RND, S_ADD, S_SCALE} state_t;

  localparam int PA_W = A_W + T_W + 1;

  state_t                      state;
  logic [K_IDX_W-1:0]          k;
  logic [J_IDX_W-1:0]          j;
  logic [T_W-1:0]              thick;
  logic signed [A_W-1:0]       acc;
  logic [A_LO_W+T_W-1:0]       pp_lo;
  logic signed [A_HI_W+T_W:0]  pp_hi;
  logic                        neg;

  logic signed [PA_W-1:0]      prod;
  logic signed [PA_W-1:0]      rnd_sum;
  logic signed [PA_W-1:0]      rnd_val;
  logic [SH_W-1:0]             sc_shift;
  logic signed [A_W-1:0]       sc_sum;
  logic signed [A_W-1:0]       sc_val;
  logic                        cfg_take;

  assign status.busy      = (state != S_IDLE);
  assign status.cfg_ready = (state == S_IDLE) && pipe_empty;
  assign cfg_take         = cfg_valid && status.cfg_ready;

  // The wide product a * T is rebuilt from two narrow partial products.
  always_comb begin
    prod    = (PA_W'(pp_hi) <<< A_LO_W) + PA_W'(pp_lo);
    rnd_sum = prod + (PA_W'(1) << (T_FRAC - 1)) - PA_W'(neg);
    rnd_val = rnd_sum >>> T_FRAC;
  end

  always_comb begin
    sc_shift = SH_W'(rescale_shift(int'(k)));
    sc_sum   = acc + (A_W'(1) << (sc_shift - SH_W'(1))) - A_W'(acc[A_W-1]);
    sc_val   = sc_sum >>> sc_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      k     <= K_IDX_W'(NUM_COEF - 1);
      j     <= '0;
      thick <= THICK_RESET;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_take) begin
            thick <= cfg_data;
            k     <= K_IDX_W'(NUM_COEF - 1);
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          acc   <= COEF_TAB[k][NUM_TERMS-1];
          j     <= J_IDX_W'(NUM_TERMS - 2);
          state <= S_MUL;
        end
        S_MUL: begin
          pp_lo <= acc[A_LO_W-1:0] * thick;
          pp_hi <= $signed(acc[A_W-1:A_LO_W]) * $signed({1'b0, thick});
          neg   <= acc[A_W-1] && (thick != '0);
          state <= S_RND;
        end
        S_RND: begin
          acc   <= rnd_val[A_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= acc + $signed(COEF_TAB[k][j]);
          if (j == '0) begin
            state <= S_SCALE;
          end else begin
            j     <= j - J_IDX_W'(1);
            state <= S_MUL;
          end
        end
        S_SCALE: begin
          coef[k] <= sc_val[B_W-1:0];
          if (k == '0) begin
            state <= S_IDLE;
          end else begin
            k     <= k - K_IDX_W'(1);
            state <= S_LOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/dlec_horner_cell.sv */
module dlec_horner_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  dlec_pkg::hc_bus_t              din,
  input  logic signed [dlec_pkg::B_W-1:0] coef,
  input  logic [dlec_pkg::SH_W-1:0]      shift,
  output dlec_pkg::hc_bus_t              dout
);
  import dlec_pkg::*;

  localparam int PROD_W = B_W + X_W + 1;

  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic [X_W-1:0]             x1;
  logic [X_W-1:0]             x2;
  logic [X_W-1:0]             x3;
  logic [B_LO_W+X_W-1:0]      pp_lo;
  logic signed [B_HI_W+X_W:0] pp_hi;
  logic                       neg1;
  logic signed [B_W-1:0]      rnd2;
  logic signed [B_W-1:0]      b3;

  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   sum;
  logic signed [PROD_W-1:0]   shifted;

  // Round to nearest with ties away from zero: add half, less one for a negative product,
  // then shift arithmetically.
  always_comb begin
    prod    = (PROD_W'(pp_hi) <<< B_LO_W) + PROD_W'(pp_lo);
    sum     = prod + (PROD_W'(1) << (shift - SH_W'(1))) - PROD_W'(neg1);
    shifted = sum >>> shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
    end
    x1    <= din.x;
    x2    <= x1;
    x3    <= x2;
    pp_lo <= din.b[B_LO_W-1:0] * din.x;
    pp_hi <= $signed(din.b[B_W-1:B_LO_W]) * $signed({1'b0, din.x});
    neg1  <= din.b[B_W-1] && (din.x != '0);
    rnd2  <= shifted[B_W-1:0];
    b3    <= rnd2 + coef;
  end

  assign dout.valid = v3;
  assign dout.x     = x3;
  assign dout.b     = b3;

endmodule
